// ===== hw/rtl/swd_pkg.sv =====
// Shared types and constants for the still window detector.
// Request structs for both channels and the control state enum.
// No dependencies.
package swd_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SAMPLE_MAX = 4095;
  localparam int unsigned MEAN_W     = 16;
  localparam int unsigned FRAC_W     = 4;
  localparam int unsigned WNUM_W     = 16;
  localparam int unsigned THR_W      = 13;
  localparam int unsigned AXES       = 3;

  localparam logic [THR_W-1:0] THR_RESET = 13'd64;

  localparam int unsigned WINDOW_LEN_DEF = 160;
  localparam int unsigned STEP_DEF       = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic [SAMPLE_W-1:0] z_sample;
  } swd_in_t;

  typedef struct packed {
    logic [WNUM_W-1:0]   window_number;
    logic [SAMPLE_W-1:0] x_lowest;
    logic [SAMPLE_W-1:0] x_highest;
    logic [MEAN_W-1:0]   x_mean;
    logic [SAMPLE_W-1:0] y_lowest;
    logic [SAMPLE_W-1:0] y_highest;
    logic [MEAN_W-1:0]   y_mean;
    logic [SAMPLE_W-1:0] z_lowest;
    logic [SAMPLE_W-1:0] z_highest;
    logic [MEAN_W-1:0]   z_mean;
  } swd_out_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MERGE,
    ST_EVAL,
    ST_DIVIDE,
    ST_EMIT
  } swd_state_e;

endpackage

// ===== hw/rtl/swd_block_cell.sv =====
// One stage of the block summary chain: per-axis min, max and sum of a block.
// Loads its upstream neighbor on shift. Uses swd_pkg.
module swd_block_cell #(
  parameter int unsigned SUM_W = 16
) (
  input  logic                                         clk_i,
  input  logic                                         shift_i,
  input  logic [swd_pkg::AXES-1:0][swd_pkg::SAMPLE_W-1:0] lo_i,
  input  logic [swd_pkg::AXES-1:0][swd_pkg::SAMPLE_W-1:0] hi_i,
  input  logic [swd_pkg::AXES-1:0][SUM_W-1:0]             sum_i,
  output logic [swd_pkg::AXES-1:0][swd_pkg::SAMPLE_W-1:0] lo_o,
  output logic [swd_pkg::AXES-1:0][swd_pkg::SAMPLE_W-1:0] hi_o,
  output logic [swd_pkg::AXES-1:0][SUM_W-1:0]             sum_o
);
  import swd_pkg::*;

  logic [AXES-1:0][SAMPLE_W-1:0] lo_q, lo_d;
  logic [AXES-1:0][SAMPLE_W-1:0] hi_q, hi_d;
  logic [AXES-1:0][SUM_W-1:0]    sum_q, sum_d;

  always_comb begin
    lo_d  = shift_i ? lo_i  : lo_q;
    hi_d  = shift_i ? hi_i  : hi_q;
    sum_d = shift_i ? sum_i : sum_q;
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    sum_q <= sum_d;
  end

  assign lo_o  = lo_q;
  assign hi_o  = hi_q;
  assign sum_o = sum_q;

endmodule

// ===== hw/rtl/swd_mean_div.sv =====
// Reciprocal-multiply divider: mean = floor(sum * 16 / DIVISOR).
// One registered multiply; done follows start in the next cycle. Uses swd_pkg.
module swd_mean_div #(
  parameter int unsigned SUM_W   = 22,
  parameter int unsigned DIVISOR = 160
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SUM_W-1:0]           sum_i,
  output logic                       done_o,
  output logic [swd_pkg::MEAN_W-1:0] mean_o
);
  import swd_pkg::*;

  localparam int unsigned DIV_W  = SUM_W + FRAC_W;
  // 2^SHIFT >= dividend range * DIVISOR keeps the rounded-up reciprocal exact
  localparam int unsigned SHIFT  = DIV_W + $clog2(DIVISOR);
  localparam int unsigned REC_W  = DIV_W + 1;
  localparam int unsigned PROD_W = DIV_W + REC_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [REC_W-1:0] RECIP = RECIP_FULL[REC_W-1:0];

  logic [DIV_W-1:0]  dvd;
  logic [PROD_W-1:0] prod;
  logic              done_q;
  logic [MEAN_W-1:0] mean_q, mean_d;

  always_comb begin
    dvd    = {sum_i, FRAC_W'(0)};
    prod   = PROD_W'(dvd) * PROD_W'(RECIP);
    mean_d = start_i ? prod[SHIFT +: MEAN_W] : mean_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
  end

  assign done_o = done_q;
  assign mean_o = mean_q;

endmodule

// ===== hw/rtl/still_window_detector.sv =====
// Still window detector top level: block accumulator, block summary chain,
// window merge, range check and mean dividers. Uses swd_pkg, swd_block_cell,
// swd_mean_div.
//
// Usage: one x/y/z sample per input request (in_valid_i / in_stall_o).
// Samples form blocks of STEP; a window is WINDOW_LEN/STEP blocks and a new
// window ends at every block once WINDOW_LEN samples have arrived. A still
// window (every axis max-min below the threshold) yields one output request
// with min, max and mean (4 fraction bits) per axis; other windows yield none.
// Throughput: one sample per cycle inside a block, while in_stall_o is low. The
// sample that closes a window is followed by rotating the summary chain, block
// by block, through the merge unit and then a range check; a still window adds
// a multiply for the means and a load of the output register. in_stall_o is
// high throughout these steps, and out_valid_o rises once the output register
// is loaded.
// The output register holds a result while out_stall_i is high and input
// samples keep being accepted; a further result waits until it is taken,
// with in_stall_o high meanwhile.
// Threshold is written through cfg_we_i/cfg_wdata_i; reset value 64.
// Reset clears the block accumulator, counters and the output valid; the
// chain contents are not cleared and are only read once fully written.
module still_window_detector #(
  parameter int unsigned WINDOW_LEN = swd_pkg::WINDOW_LEN_DEF,
  parameter int unsigned STEP       = swd_pkg::STEP_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  swd_pkg::swd_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output swd_pkg::swd_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [swd_pkg::THR_W-1:0] cfg_wdata_i
);
  import swd_pkg::*;

  localparam int unsigned NBLK   = WINDOW_LEN / STEP;
  localparam int unsigned BSUM_W = $clog2(STEP * SAMPLE_MAX + 1);
  localparam int unsigned WSUM_W = $clog2(NBLK * STEP * SAMPLE_MAX + 1);
  localparam int unsigned CNT_W  = $clog2(NBLK + 1);
  localparam int unsigned SIB_W  = $clog2(STEP + 1);

  swd_state_e state_q, state_d;

  logic [THR_W-1:0] thr_q;
  logic [SIB_W-1:0] sib_q, sib_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] mcnt_q, mcnt_d;
  logic [WNUM_W-1:0] blocks_q, blocks_d;

  logic [AXES-1:0][SAMPLE_W-1:0] acc_lo_q, acc_lo_d, nb_lo;
  logic [AXES-1:0][SAMPLE_W-1:0] acc_hi_q, acc_hi_d, nb_hi;
  logic [AXES-1:0][BSUM_W-1:0]   acc_sum_q, acc_sum_d, nb_sum;
  logic [AXES-1:0][SAMPLE_W-1:0] smp;

  logic [AXES-1:0][SAMPLE_W-1:0] w_lo_q, w_lo_d;
  logic [AXES-1:0][SAMPLE_W-1:0] w_hi_q, w_hi_d;
  logic [AXES-1:0][WSUM_W-1:0]   w_sum_q, w_sum_d;

  logic [AXES-1:0][SAMPLE_W-1:0] ch_lo  [NBLK+1];
  logic [AXES-1:0][SAMPLE_W-1:0] ch_hi  [NBLK+1];
  logic [AXES-1:0][BSUM_W-1:0]   ch_sum [NBLK+1];

  logic [AXES-1:0][MEAN_W-1:0] mean;
  logic [AXES-1:0]             div_done;

  logic accept, push, window_full, rotate, still, div_start, out_load;
  logic out_valid_q, out_valid_d;
  swd_out_t out_q, out_d;

  // ---------------- threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // ---------------- control outputs
  always_comb begin
    in_stall_o  = (state_q != ST_ACCUM);
    accept      = in_valid_i && (state_q == ST_ACCUM);
    push        = accept && (sib_q == SIB_W'(STEP - 1));
    window_full = push && (fill_q >= CNT_W'(NBLK - 1));
    rotate      = (state_q == ST_MERGE);
    div_start   = (state_q == ST_EVAL) && still;
    out_load    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  end

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM:  if (window_full) state_d = ST_MERGE;
      ST_MERGE:  if (mcnt_q == CNT_W'(NBLK - 1)) state_d = ST_EVAL;
      ST_EVAL:   state_d = still ? ST_DIVIDE : ST_ACCUM;
      ST_DIVIDE: if (&div_done) state_d = ST_EMIT;
      ST_EMIT:   if (out_load) state_d = ST_ACCUM;
      default:   state_d = ST_ACCUM;
    endcase
  end

  // ---------------- block accumulator
  assign smp[0] = in_data_i.x_sample;
  assign smp[1] = in_data_i.y_sample;
  assign smp[2] = in_data_i.z_sample;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      nb_lo[a]  = (smp[a] < acc_lo_q[a]) ? smp[a] : acc_lo_q[a];
      nb_hi[a]  = (smp[a] > acc_hi_q[a]) ? smp[a] : acc_hi_q[a];
      nb_sum[a] = acc_sum_q[a] + BSUM_W'(smp[a]);
    end
    acc_lo_d  = acc_lo_q;
    acc_hi_d  = acc_hi_q;
    acc_sum_d = acc_sum_q;
    sib_d     = sib_q;
    fill_d    = fill_q;
    blocks_d  = blocks_q;
    if (push) begin
      for (int a = 0; a < AXES; a++) begin
        acc_lo_d[a]  = SAMPLE_W'(SAMPLE_MAX);
        acc_hi_d[a]  = '0;
        acc_sum_d[a] = '0;
      end
      sib_d    = '0;
      blocks_d = blocks_q + WNUM_W'(1);
      if (fill_q != CNT_W'(NBLK)) fill_d = fill_q + CNT_W'(1);
    end else if (accept) begin
      acc_lo_d  = nb_lo;
      acc_hi_d  = nb_hi;
      acc_sum_d = nb_sum;
      sib_d     = sib_q + SIB_W'(1);
    end
  end

  // ---------------- summary chain; head takes a new block or the tail
  assign ch_lo[0]  = push ? nb_lo  : ch_lo[NBLK];
  assign ch_hi[0]  = push ? nb_hi  : ch_hi[NBLK];
  assign ch_sum[0] = push ? nb_sum : ch_sum[NBLK];

  for (genvar k = 0; k < NBLK; k++) begin : g_chain
    swd_block_cell #(
      .SUM_W (BSUM_W)
    ) u_stage (
      .clk_i   (clk_i),
      .shift_i (push || rotate),
      .lo_i    (ch_lo[k]),
      .hi_i    (ch_hi[k]),
      .sum_i   (ch_sum[k]),
      .lo_o    (ch_lo[k+1]),
      .hi_o    (ch_hi[k+1]),
      .sum_o   (ch_sum[k+1])
    );
  end

  // ---------------- window merge, one block per cycle from the tail
  always_comb begin
    w_lo_d  = w_lo_q;
    w_hi_d  = w_hi_q;
    w_sum_d = w_sum_q;
    mcnt_d  = mcnt_q;
    if (rotate) begin
      mcnt_d = (mcnt_q == CNT_W'(NBLK - 1)) ? '0 : mcnt_q + CNT_W'(1);
      for (int a = 0; a < AXES; a++) begin
        if (mcnt_q == '0) begin
          w_lo_d[a]  = ch_lo[NBLK][a];
          w_hi_d[a]  = ch_hi[NBLK][a];
          w_sum_d[a] = WSUM_W'(ch_sum[NBLK][a]);
        end else begin
          w_lo_d[a]  = (ch_lo[NBLK][a] < w_lo_q[a]) ? ch_lo[NBLK][a] : w_lo_q[a];
          w_hi_d[a]  = (ch_hi[NBLK][a] > w_hi_q[a]) ? ch_hi[NBLK][a] : w_hi_q[a];
          w_sum_d[a] = w_sum_q[a] + WSUM_W'(ch_sum[NBLK][a]);
        end
      end
    end
  end

  always_comb begin
    still = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if (THR_W'(w_hi_q[a] - w_lo_q[a]) >= thr_q) still = 1'b0;
    end
  end

  // ---------------- mean dividers
  for (genvar a = 0; a < AXES; a++) begin : g_div
    swd_mean_div #(
      .SUM_W   (WSUM_W),
      .DIVISOR (WINDOW_LEN)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .sum_i   (w_sum_q[a]),
      .done_o  (div_done[a]),
      .mean_o  (mean[a])
    );
  end

  // ---------------- output register
  always_comb begin
    out_d = out_q;
    if (out_load) begin
      out_d.window_number = blocks_q - WNUM_W'(NBLK);
      out_d.x_lowest      = w_lo_q[0];
      out_d.x_highest     = w_hi_q[0];
      out_d.x_mean        = mean[0];
      out_d.y_lowest      = w_lo_q[1];
      out_d.y_highest     = w_hi_q[1];
      out_d.y_mean        = mean[1];
      out_d.z_lowest      = w_lo_q[2];
      out_d.z_highest     = w_hi_q[2];
      out_d.z_mean        = mean[2];
    end
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  // ---------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      sib_q       <= '0;
      fill_q      <= '0;
      mcnt_q      <= '0;
      blocks_q    <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        acc_lo_q[a]  <= SAMPLE_W'(SAMPLE_MAX);
        acc_hi_q[a]  <= '0;
        acc_sum_q[a] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sib_q       <= sib_d;
      fill_q      <= fill_d;
      mcnt_q      <= mcnt_d;
      blocks_q    <= blocks_d;
      out_valid_q <= out_valid_d;
      acc_lo_q    <= acc_lo_d;
      acc_hi_q    <= acc_hi_d;
      acc_sum_q   <= acc_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_lo_q  <= w_lo_d;
    w_hi_q  <= w_hi_d;
    w_sum_q <= w_sum_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(NBLK))
    else $error("fill count above chain depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result appeared outside emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (fill_q == CNT_W'(NBLK)))
    else $error("merge started before chain was full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> $past(state_q == ST_MERGE))
    else $error("range check without merge");

endmodule
